### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions on a clock, with or without an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// I2C master package
// Item types, configuration types and codes shared by the I2C master files.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // Operation codes carried in the mode field
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_NEXT  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_SETUP   = 2'd0;
    localparam logic [1:0] REG_BIT     = 2'd1;
    localparam logic [1:0] REG_RECOVER = 2'd2;

    // Configuration reset values
    localparam logic [9:0]  SETUP_RST   = 10'd4;
    localparam logic [9:0]  BIT_RST     = 10'd20;
    localparam logic [19:0] RECOVER_RST = 20'd10000;

    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] chip_addr;
        logic [7:0] reg_index;
        logic [7:0] data_byte;
        logic       last_byte;
        logic       sda_in;
    } t_in_item;

    typedef struct packed {
        logic       scl;
        logic       sda_release;
        logic       busy_res;
        logic       data_request;
        logic [7:0] read_data;
        logic       read_valid;
        logic       nack_seen;
        logic       done_res;
    } t_out_item;

    typedef struct packed {
        logic [9:0]  setup_ticks;
        logic [9:0]  bit_phase_ticks;
        logic [19:0] write_recovery_ticks;
    } t_cfg;

endpackage

### rtl/i2cm_if.sv
// ----------------------------------------------------------------------------
// I2C master item channels
// Valid/ready channels for input ticks and result items.
// ----------------------------------------------------------------------------
interface i2cm_in_if import i2cm_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

interface i2cm_out_if import i2cm_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

### rtl/i2c_master_register_access.sv
// One input item is one tick of the I2C timebase with the sampled SDA level, and each
// item yields exactly one result item carrying the SCL and SDA drive and status for that
// tick. The block takes one item per clock cycle unless a result is stalled; the result
// is written to the output register on acceptance, and a new item is taken while that
// result is still waiting as long as the downstream side takes it in the same cycle.
// Throughput is set by the single result register. Timing registers sit on the APB port at
// byte addresses 0 (setup ticks), 4 (bit phase ticks) and 8 (write recovery ticks).
// ----------------------------------------------------------------------------
// I2C master for register access
// Top level: APB timing registers, item handshake and result register.
// ----------------------------------------------------------------------------
module i2c_master_register_access import i2cm_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    i2cm_in_if.sink      i_in,
    i2cm_out_if.source   o_out,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    t_cfg      r_cfg;
    t_out_item r_res;
    logic      r_out_vld;
    t_out_item res;
    logic      step;
    logic      cfg_wr;

    i2cm_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (i_in.data),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    // Accept an item whenever the result register is free or draining
    assign i_in.ready = !r_out_vld || o_out.ready;
    assign step       = i_in.valid && i_in.ready;

    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_res;

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= res;
        end
    end

    // Write the timing registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setup_ticks          <= SETUP_RST;
            r_cfg.bit_phase_ticks      <= BIT_RST;
            r_cfg.write_recovery_ticks <= RECOVER_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_SETUP:   r_cfg.setup_ticks          <= pwdata[9:0];
                REG_BIT:     r_cfg.bit_phase_ticks      <= pwdata[9:0];
                REG_RECOVER: r_cfg.write_recovery_ticks <= pwdata[19:0];
                default: ;
            endcase
        end
    end

    // Read back the timing registers
    always_comb begin
        case (paddr[3:2])
            REG_SETUP:   prdata = {22'd0, r_cfg.setup_ticks};
            REG_BIT:     prdata = {22'd0, r_cfg.bit_phase_ticks};
            REG_RECOVER: prdata = {12'd0, r_cfg.write_recovery_ticks};
            default:     prdata = '0;
        endcase
    end

endmodule

### rtl/i2cm_engine.sv
// ----------------------------------------------------------------------------
// I2C master engine
// Bus sequencer state and the per-tick next-state and line-drive logic.
// ----------------------------------------------------------------------------
module i2cm_engine import i2cm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_res
);

    typedef enum logic [4:0] {
        PH_IDLE, PH_S1, PH_S2, PH_S3, PH_TXL, PH_TXH, PH_TXD, PH_TXT,
        PH_A1, PH_A2, PH_A3, PH_WAIT, PH_RXL, PH_RXH, PH_N1, PH_N2,
        PH_N3, PH_P0, PH_P1, PH_REC
    } t_phase;

    typedef enum logic [1:0] {ST_ADDR, ST_REG, ST_RADDR, ST_DATA} t_stage;

    t_phase      r_phase, n_phase;
    t_stage      r_stage, n_stage;
    logic [19:0] r_tick, n_tick;
    logic [2:0]  r_bit, n_bit;
    logic [7:0]  r_shift, n_shift;
    logic [6:0]  r_addr, n_addr;
    logic [7:0]  r_reg, n_reg;
    logic [8:0]  r_pend, n_pend;
    logic        r_pend_vld, n_pend_vld;
    logic        r_is_read, n_is_read;
    logic        r_nack, n_nack;
    logic        r_cur_last, n_cur_last;
    logic        r_last_q, n_last_q;
    logic [7:0]  r_rd, n_rd;

    logic [19:0] dur;
    logic        end_t;
    logic        do_next;
    logic        do_load;
    logic [7:0]  load_byte;
    logic [7:0]  rx_shift;

    // Work out one tick: take the item, drive the lines, advance the sequence
    always_comb begin
        n_phase    = r_phase;
        n_stage    = r_stage;
        n_tick     = r_tick;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_addr     = r_addr;
        n_reg      = r_reg;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        n_is_read  = r_is_read;
        n_nack     = r_nack;
        n_cur_last = r_cur_last;
        n_last_q   = r_last_q;
        n_rd       = r_rd;
        o_res      = '0;
        do_next    = 1'b0;
        do_load    = 1'b0;
        load_byte  = '0;
        rx_shift   = {r_shift[6:0], i_item.sda_in};

        // Begin a transaction or buffer the next write byte
        if (r_phase == PH_IDLE) begin
            if (i_item.mode == MODE_WRITE || i_item.mode == MODE_READ) begin
                n_addr     = i_item.chip_addr;
                n_reg      = i_item.reg_index;
                n_is_read  = (i_item.mode == MODE_READ);
                n_nack     = 1'b0;
                n_stage    = ST_ADDR;
                n_cur_last = 1'b0;
                if (i_item.mode == MODE_WRITE) begin
                    n_pend     = {i_item.last_byte, i_item.data_byte};
                    n_pend_vld = 1'b1;
                    n_last_q   = i_item.last_byte;
                end else begin
                    n_pend     = '0;
                    n_pend_vld = 1'b0;
                    n_last_q   = 1'b1;
                end
                n_phase = PH_S1;
                n_tick  = '0;
            end
        end else if (i_item.mode == MODE_NEXT && !r_is_read && !r_last_q && !r_pend_vld) begin
            n_pend     = {i_item.last_byte, i_item.data_byte};
            n_pend_vld = 1'b1;
            n_last_q   = i_item.last_byte;
        end

        // Drive the lines for this phase
        case (n_phase)
            PH_IDLE, PH_S1: begin
                o_res.scl = 1'b1; o_res.sda_release = 1'b1;
            end
            PH_S2, PH_P1: begin
                o_res.scl = 1'b1; o_res.sda_release = 1'b0;
            end
            PH_S3, PH_P0: begin
                o_res.scl = 1'b0; o_res.sda_release = 1'b0;
            end
            PH_TXL, PH_TXD, PH_TXT: begin
                o_res.scl = 1'b0; o_res.sda_release = n_shift[~n_bit];
            end
            PH_TXH: begin
                o_res.scl = 1'b1; o_res.sda_release = n_shift[~n_bit];
            end
            PH_A2, PH_RXH, PH_N2, PH_REC: begin
                o_res.scl = 1'b1; o_res.sda_release = 1'b1;
            end
            default: begin
                o_res.scl = 1'b0; o_res.sda_release = 1'b1;
            end
        endcase
        o_res.busy_res     = (n_phase != PH_IDLE);
        o_res.data_request = o_res.busy_res && !n_is_read && !n_last_q && !n_pend_vld;

        // Sample a read bit on the first tick of SCL high
        if (n_phase == PH_RXH && n_tick == '0) begin
            n_shift = rx_shift;
            if (n_bit == 3'd7) begin
                n_rd             = rx_shift;
                o_res.read_valid = 1'b1;
            end
        end

        // Interval length of the current phase
        case (n_phase)
            PH_TXL, PH_TXH, PH_TXD, PH_TXT, PH_RXL, PH_RXH:
                dur = (i_cfg.bit_phase_ticks == '0) ? 20'd1 : {10'd0, i_cfg.bit_phase_ticks};
            PH_P0:
                dur = 20'd1;
            PH_REC:
                dur = (i_cfg.write_recovery_ticks == '0) ? 20'd1 : i_cfg.write_recovery_ticks;
            default:
                dur = (i_cfg.setup_ticks == '0) ? 20'd1 : {10'd0, i_cfg.setup_ticks};
        endcase
        end_t = (n_tick >= dur - 20'd1);

        // Flag a high acknowledge on the last tick of its SCL high interval
        if (n_phase == PH_A2 && end_t && i_item.sda_in) begin
            n_nack = 1'b1;
        end

        // Advance the sequence
        if (n_phase == PH_WAIT) begin
            do_next = n_pend_vld;
        end else if (n_phase != PH_IDLE && !end_t) begin
            n_tick = n_tick + 20'd1;
        end else if (n_phase != PH_IDLE) begin
            n_tick = '0;
            case (n_phase)
                PH_S1: n_phase = PH_S2;
                PH_S2: n_phase = PH_S3;
                PH_S3: begin
                    do_load   = 1'b1;
                    load_byte = {n_addr, (n_stage == ST_RADDR)};
                end
                PH_TXL: n_phase = PH_TXH;
                PH_TXH: n_phase = PH_TXD;
                PH_TXD: begin
                    if (n_bit == 3'd7) begin
                        n_phase = PH_TXT;
                    end else begin
                        n_bit   = n_bit + 3'd1;
                        n_phase = PH_TXL;
                    end
                end
                PH_TXT: n_phase = PH_A1;
                PH_A1:  n_phase = PH_A2;
                PH_A2:  n_phase = PH_A3;
                PH_A3: begin
                    case (n_stage)
                        ST_ADDR: begin
                            n_stage   = ST_REG;
                            do_load   = 1'b1;
                            load_byte = n_reg;
                        end
                        ST_REG: begin
                            if (n_is_read) begin
                                n_stage = ST_RADDR;
                                n_phase = PH_S1;
                            end else begin
                                n_stage = ST_DATA;
                                do_next = 1'b1;
                            end
                        end
                        ST_RADDR: begin
                            n_shift = '0;
                            n_bit   = '0;
                            n_phase = PH_RXL;
                        end
                        default: begin
                            if (n_cur_last) begin
                                n_phase = PH_P0;
                            end else begin
                                do_next = 1'b1;
                            end
                        end
                    endcase
                end
                PH_RXL: n_phase = PH_RXH;
                PH_RXH: begin
                    if (n_bit == 3'd7) begin
                        n_phase = PH_N1;
                    end else begin
                        n_bit   = n_bit + 3'd1;
                        n_phase = PH_RXL;
                    end
                end
                PH_N1: n_phase = PH_N2;
                PH_N2: n_phase = PH_N3;
                PH_N3: n_phase = PH_P0;
                PH_P0: n_phase = PH_P1;
                PH_P1: begin
                    if (!n_is_read && i_cfg.write_recovery_ticks != '0) begin
                        n_phase = PH_REC;
                    end else begin
                        o_res.done_res = 1'b1;
                        n_phase        = PH_IDLE;
                    end
                end
                default: begin
                    o_res.done_res = 1'b1;
                    n_phase        = PH_IDLE;
                end
            endcase
        end

        // Pull the buffered byte into the shifter, or wait for one
        if (do_next) begin
            n_tick = '0;
            if (n_pend_vld) begin
                n_cur_last = n_pend[8];
                n_pend_vld = 1'b0;
                do_load    = 1'b1;
                load_byte  = n_pend[7:0];
            end else begin
                n_phase = PH_WAIT;
            end
        end

        // Load a byte for transmission
        if (do_load) begin
            n_shift = load_byte;
            n_bit   = '0;
            n_phase = PH_TXL;
            n_tick  = '0;
        end

        o_res.read_data = n_rd;
        o_res.nack_seen = n_nack;
    end

    // Hold the sequencer state; advance on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_stage    <= ST_ADDR;
            r_tick     <= '0;
            r_bit      <= '0;
            r_shift    <= '0;
            r_addr     <= '0;
            r_reg      <= '0;
            r_pend     <= '0;
            r_pend_vld <= 1'b0;
            r_is_read  <= 1'b0;
            r_nack     <= 1'b0;
            r_cur_last <= 1'b0;
            r_last_q   <= 1'b0;
            r_rd       <= '0;
        end else if (i_step) begin
            r_phase    <= n_phase;
            r_stage    <= n_stage;
            r_tick     <= n_tick;
            r_bit      <= n_bit;
            r_shift    <= n_shift;
            r_addr     <= n_addr;
            r_reg      <= n_reg;
            r_pend     <= n_pend;
            r_pend_vld <= n_pend_vld;
            r_is_read  <= n_is_read;
            r_nack     <= n_nack;
            r_cur_last <= n_cur_last;
            r_last_q   <= n_last_q;
            r_rd       <= n_rd;
        end
    end

endmodule

### rtl/i2cm_checker.sv
// ----------------------------------------------------------------------------
// I2C master port checker
// Port-level assertions on the I2C master, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cm_checker import i2cm_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_vld,
    input logic      i_in_rdy,
    input logic      i_out_vld,
    input logic      i_out_rdy,
    input t_out_item i_res
);

    property p_out_hold;
        i_out_vld && !i_out_rdy |=> i_out_vld && $stable(i_res);
    endproperty

    property p_rst_clear;
        !i_rst_n |=> !i_out_vld;
    endproperty

    property p_res_src;
        i_out_vld && !$past(i_out_vld) |-> $past(i_in_vld && i_in_rdy);
    endproperty

    property p_done_busy;
        i_out_vld && i_res.done_res |-> i_res.busy_res;
    endproperty

    property p_rd_scl;
        i_out_vld && i_res.read_valid |-> i_res.scl && i_res.busy_res;
    endproperty

    // A stalled result holds
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, p_out_hold, "result changed while stalled")

    // No result straight out of reset
    `ASSERT_ALWAYS(a_rst_clear, i_clk, p_rst_clear, "result valid after reset")

    // A new result follows an accepted item
    `ASSERT_CLK(a_res_src, i_clk, i_rst_n, p_res_src, "result without an accepted item")

    // Completion only on a busy tick
    `ASSERT_CLK(a_done_busy, i_clk, i_rst_n, p_done_busy, "done outside a transaction")

    // Read data appears only with SCL high during a transaction
    `ASSERT_CLK(a_rd_scl, i_clk, i_rst_n, p_rd_scl, "read data outside SCL high")

endmodule

bind i2c_master_register_access i2cm_checker u_i2cm_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_in_vld  (i_in.valid),
    .i_in_rdy  (i_in.ready),
    .i_out_vld (o_out.valid),
    .i_out_rdy (o_out.ready),
    .i_res     (o_out.data)
);

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C register-access master testbench
// Feeds timebase ticks with random handshake gaps and checks every result
// item against an in-bench model of the bus sequencer, across several timing
// settings written over the APB port.
// ----------------------------------------------------------------------------
module tb_top;
    import i2cm_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int N_PLANS    = 6;

    // Bus sequencer phases and transfer stages of the model
    typedef enum logic [4:0] {
        BUS_IDLE, START_HI, START_LO, START_HOLD, TX_LO, TX_HI, TX_HOLD, TX_END,
        ACK_LO, ACK_HI, ACK_TAIL, BYTE_WAIT, RX_LO, RX_HI, NAK_LO, NAK_HI,
        NAK_TAIL, STOP_LO, STOP_HI, RECOVER
    } t_bus_phase;

    typedef enum logic [1:0] {STG_ADDR, STG_REG, STG_RADDR, STG_DATA} t_stage;

    // Timing plans: setup, bit phase, recovery, number of ticks
    int unsigned timing_plan [N_PLANS][4] = '{
        '{1, 1, 2, 100},
        '{0, 1, 0, 80},
        '{2, 0, 5, 80},
        '{1023, 1023, 1048575, 30},
        '{1, 1, 1048575, 60},
        '{3, 2, 7, 50}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    i2cm_in_if  in_ch ();
    i2cm_out_if out_ch ();

    i2c_master_register_access uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_in_item  tick_queue [$];
    t_out_item expected_lines [$];
    int        ticks_sent  = 0;
    int        ticks_taken = 0;
    int        fail_count  = 0;
    int        idle_cycles = 0;
    int        send_gap    = 0;
    int        stall_left  = 0;
    bit        in_fire     = 1'b0;
    bit        no_gaps     = 1'b0;
    int        n_writes = 0, n_reads = 0, n_rbytes = 0, n_nacked = 0;

    // Model state
    t_cfg        timing;
    t_bus_phase  bus_phase;
    t_stage      stage;
    logic [19:0] span_cnt;
    logic [3:0]  bit_idx;
    logic [7:0]  shifter;
    logic [6:0]  dev_sel;
    logic [7:0]  reg_sel;
    logic [8:0]  byte_buf;
    logic [7:0]  rd_byte;
    logic        buf_full, reading, ack_missed, tail_byte, last_taken;

    function automatic void model_reset();
        timing     = '{setup_ticks: SETUP_RST, bit_phase_ticks: BIT_RST,
                       write_recovery_ticks: RECOVER_RST};
        bus_phase  = BUS_IDLE;
        stage      = STG_ADDR;
        span_cnt   = '0;
        bit_idx    = '0;
        shifter    = '0;
        dev_sel    = '0;
        reg_sel    = '0;
        byte_buf   = '0;
        rd_byte    = '0;
        buf_full   = 1'b0;
        reading    = 1'b0;
        ack_missed = 1'b0;
        tail_byte  = 1'b0;
        last_taken = 1'b0;
    endfunction

    function automatic logic [19:0] at_least_one(logic [19:0] v);
        return (v == '0) ? 20'd1 : v;
    endfunction

    // Length of the current phase in ticks
    function automatic logic [19:0] span_len();
        case (bus_phase)
            TX_LO, TX_HI, TX_HOLD, TX_END, RX_LO, RX_HI:
                return at_least_one({10'd0, timing.bit_phase_ticks});
            STOP_LO: return 20'd1;
            RECOVER: return at_least_one(timing.write_recovery_ticks);
            default: return at_least_one({10'd0, timing.setup_ticks});
        endcase
    endfunction

    function automatic void enter(t_bus_phase p);
        bus_phase = p;
        span_cnt  = '0;
    endfunction

    function automatic void load_byte(logic [7:0] b);
        shifter = b;
        bit_idx = '0;
        enter(TX_LO);
    endfunction

    // Start the buffered write byte, or hold SCL low until one arrives
    function automatic void take_buffered();
        if (buf_full) begin
            tail_byte = byte_buf[8];
            buf_full  = 1'b0;
            load_byte(byte_buf[7:0]);
        end else begin
            enter(BYTE_WAIT);
        end
    endfunction

    function automatic logic byte_wanted();
        return bus_phase != BUS_IDLE && !reading && !last_taken && !buf_full;
    endfunction

    // Advance the sequencer by one tick and return the line and status levels
    function automatic t_out_item i2c_tick(t_in_item it);
        t_out_item r;
        logic      fin;
        r = '0;
        if (bus_phase == BUS_IDLE) begin
            if (it.mode == MODE_WRITE || it.mode == MODE_READ) begin
                dev_sel    = it.chip_addr;
                reg_sel    = it.reg_index;
                reading    = (it.mode == MODE_READ);
                ack_missed = 1'b0;
                stage      = STG_ADDR;
                tail_byte  = 1'b0;
                if (it.mode == MODE_WRITE) begin
                    byte_buf   = {it.last_byte, it.data_byte};
                    buf_full   = 1'b1;
                    last_taken = it.last_byte;
                end else begin
                    byte_buf   = '0;
                    buf_full   = 1'b0;
                    last_taken = 1'b1;
                end
                enter(START_HI);
            end
        end else if (it.mode == MODE_NEXT && !reading && !last_taken && !buf_full) begin
            byte_buf   = {it.last_byte, it.data_byte};
            buf_full   = 1'b1;
            last_taken = it.last_byte;
        end

        // Line levels of this tick
        case (bus_phase)
            BUS_IDLE, START_HI: {r.scl, r.sda_release} = 2'b11;
            START_LO, STOP_HI: {r.scl, r.sda_release} = 2'b10;
            START_HOLD, STOP_LO: {r.scl, r.sda_release} = 2'b00;
            TX_LO, TX_HOLD, TX_END: begin
                r.scl = 1'b0;
                r.sda_release = shifter[3'd7 - bit_idx[2:0]];
            end
            TX_HI: begin
                r.scl = 1'b1;
                r.sda_release = shifter[3'd7 - bit_idx[2:0]];
            end
            ACK_HI, RX_HI, NAK_HI, RECOVER: {r.scl, r.sda_release} = 2'b11;
            default: {r.scl, r.sda_release} = 2'b01;
        endcase
        r.busy_res     = (bus_phase != BUS_IDLE);
        r.data_request = byte_wanted();

        // Sample a read bit on the first tick of SCL high
        if (bus_phase == RX_HI && span_cnt == '0) begin
            shifter = {shifter[6:0], it.sda_in};
            if (bit_idx == 4'd7) begin
                rd_byte = shifter;
                r.read_valid = 1'b1;
            end
        end

        fin = ({1'b0, span_cnt} + 21'd1) >= {1'b0, span_len()};
        if (bus_phase == ACK_HI && fin && it.sda_in)
            ack_missed = 1'b1;

        if (bus_phase == BYTE_WAIT) begin
            if (buf_full)
                take_buffered();
        end else if (bus_phase != BUS_IDLE && !fin) begin
            span_cnt = span_cnt + 20'd1;
        end else if (bus_phase != BUS_IDLE) begin
            case (bus_phase)
                START_HI:   enter(START_LO);
                START_LO:   enter(START_HOLD);
                START_HOLD: load_byte({dev_sel, stage == STG_RADDR});
                TX_LO:      enter(TX_HI);
                TX_HI:      enter(TX_HOLD);
                TX_HOLD: begin
                    if (bit_idx >= 4'd7) begin
                        enter(TX_END);
                    end else begin
                        bit_idx = bit_idx + 4'd1;
                        enter(TX_LO);
                    end
                end
                TX_END:     enter(ACK_LO);
                ACK_LO:     enter(ACK_HI);
                ACK_HI:     enter(ACK_TAIL);
                ACK_TAIL: begin
                    case (stage)
                        STG_ADDR: begin
                            stage = STG_REG;
                            load_byte(reg_sel);
                        end
                        STG_REG: begin
                            if (reading) begin
                                stage = STG_RADDR;
                                enter(START_HI);
                            end else begin
                                stage = STG_DATA;
                                take_buffered();
                            end
                        end
                        STG_RADDR: begin
                            shifter = '0;
                            bit_idx = '0;
                            enter(RX_LO);
                        end
                        default: begin
                            if (tail_byte)
                                enter(STOP_LO);
                            else
                                take_buffered();
                        end
                    endcase
                end
                RX_LO:      enter(RX_HI);
                RX_HI: begin
                    if (bit_idx >= 4'd7) begin
                        enter(NAK_LO);
                    end else begin
                        bit_idx = bit_idx + 4'd1;
                        enter(RX_LO);
                    end
                end
                NAK_LO:     enter(NAK_HI);
                NAK_HI:     enter(NAK_TAIL);
                NAK_TAIL:   enter(STOP_LO);
                STOP_LO:    enter(STOP_HI);
                STOP_HI: begin
                    if (!reading && timing.write_recovery_ticks != '0) begin
                        enter(RECOVER);
                    end else begin
                        r.done_res = 1'b1;
                        enter(BUS_IDLE);
                    end
                end
                default: begin
                    r.done_res = 1'b1;
                    enter(BUS_IDLE);
                end
            endcase
        end

        r.read_data = rd_byte;
        r.nack_seen = ack_missed;
        return r;
    endfunction

    // Random gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 70)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Predict on every accepted tick
    always @(posedge i_clk) begin
        t_out_item r;
        in_fire = i_rst_n && in_ch.valid && in_ch.ready;
        if (in_fire) begin
            r = i2c_tick(in_ch.data);
            expected_lines.push_back(r);
            ticks_taken++;
            if (r.read_valid)
                n_rbytes++;
            if (r.done_res) begin
                if (reading)
                    n_reads++;
                else
                    n_writes++;
                if (r.nack_seen)
                    n_nacked++;
            end
        end
    end

    // Drive pending ticks, holding each until it is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
        end else if (!in_ch.valid || in_fire) begin
            if (send_gap > 0) begin
                in_ch.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (tick_queue.size() != 0) begin
                in_ch.data  <= tick_queue.pop_front();
                in_ch.valid <= 1'b1;
                send_gap <= pick_gap();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Stall the result side at random
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                out_ch.ready <= 1'b1;
                stall_left <= pick_gap();
            end
        end
    end

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            fail_count++;
            if (fail_count <= 40)
                $error("%s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // Compare each result item with the oldest prediction
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (expected_lines.size() == 0) begin
                fail_count++;
                if (fail_count <= 40)
                    $error("result item with no tick pending: %h", got);
            end else begin
                want = expected_lines.pop_front();
                check_field("scl", 8'(want.scl), 8'(got.scl));
                check_field("sda_release", 8'(want.sda_release), 8'(got.sda_release));
                check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
                check_field("data_request", 8'(want.data_request), 8'(got.data_request));
                check_field("read_data", want.read_data, got.read_data);
                check_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
                check_field("nack_seen", 8'(want.nack_seen), 8'(got.nack_seen));
                check_field("done_res", 8'(want.done_res), 8'(got.done_res));
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // Queue one tick and wait until it is taken, so the model is current
    task automatic push_tick(t_in_item it);
        tick_queue.push_back(it);
        ticks_sent++;
        do begin
            @(posedge i_clk);
            #1;
        end while (ticks_taken != ticks_sent);
    endtask

    task automatic send(logic [1:0] m, logic [6:0] a, logic [7:0] g, logic [7:0] d,
                        logic l, logic s);
        t_in_item it;
        it = '{mode: m, chip_addr: a, reg_index: g, data_byte: d, last_byte: l, sda_in: s};
        push_tick(it);
    endtask

    task automatic run_to_idle(logic s);
        while (bus_phase != BUS_IDLE)
            send(MODE_TICK, 7'h00, 8'h00, 8'h00, 1'b0, s);
    endtask

    // Mostly well-formed transactions with random content, some noise
    task automatic random_tick();
        t_in_item it;
        int       r;
        it.chip_addr = 7'($urandom_range(0, 127));
        it.reg_index = 8'($urandom_range(0, 255));
        it.data_byte = 8'($urandom_range(0, 255));
        it.last_byte = 1'($urandom_range(0, 1));
        it.sda_in    = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (bus_phase == BUS_IDLE) begin
            if (r < 45) begin
                it.mode = MODE_WRITE;
                it.last_byte = ($urandom_range(0, 3) == 0);
            end else if (r < 85) begin
                it.mode = MODE_READ;
            end else if (r < 93) begin
                it.mode = MODE_TICK;
            end else begin
                it.mode = MODE_NEXT;
            end
        end else if (byte_wanted()) begin
            if (r < 30) begin
                it.mode = MODE_NEXT;
                it.last_byte = ($urandom_range(0, 2) == 0);
            end else if (r < 34) begin
                it.mode = $urandom_range(0, 1) ? MODE_WRITE : MODE_READ;
            end else begin
                it.mode = MODE_TICK;
            end
        end else begin
            if (r < 88)
                it.mode = MODE_TICK;
            else if (r < 94)
                it.mode = MODE_NEXT;
            else
                it.mode = $urandom_range(0, 1) ? MODE_WRITE : MODE_READ;
        end
        // Acknowledge mostly given, now and then missed
        if (bus_phase == ACK_LO || bus_phase == ACK_HI || bus_phase == ACK_TAIL)
            it.sda_in = ($urandom_range(0, 99) < 15);
        push_tick(it);
    endtask

    // Wait until every predicted result has come back
    task automatic drain();
        do begin
            @(posedge i_clk);
            #1;
        end while (ticks_taken != ticks_sent || expected_lines.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_readback(logic [1:0] idx);
        logic [31:0] want;
        case (idx)
            REG_SETUP: want = {22'd0, timing.setup_ticks};
            REG_BIT:   want = {22'd0, timing.bit_phase_ticks};
            default:   want = {12'd0, timing.write_recovery_ticks};
        endcase
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            fail_count++;
            $error("register %0d: expected %0h, got %0h", idx, want, prdata);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_SETUP: timing.setup_ticks = val[9:0];
            REG_BIT:   timing.bit_phase_ticks = val[9:0];
            default:   timing.write_recovery_ticks = val[19:0];
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_readback(idx);
    endtask

    task automatic set_timing(int unsigned s, int unsigned b, int unsigned rec);
        drain();
        reg_write(REG_SETUP, s);
        reg_write(REG_BIT, b);
        reg_write(REG_RECOVER, rec);
    endtask

    initial begin : main
        int p;
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        model_reset();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset values of the timing registers
        reg_readback(REG_SETUP);
        reg_readback(REG_BIT);
        reg_readback(REG_RECOVER);

        // Zero intervals and zero recovery: every timed phase lasts one tick
        set_timing(0, 0, 0);
        send(MODE_NEXT, 7'h7F, 8'hFF, 8'hFF, 1'b1, 1'b1);   // byte offered while idle
        send(MODE_TICK, 7'h7F, 8'hFF, 8'hFF, 1'b1, 1'b1);
        send(MODE_WRITE, 7'h7F, 8'h00, 8'hFF, 1'b0, 1'b0);
        send(MODE_READ, 7'h00, 8'hFF, 8'h00, 1'b1, 1'b0);   // begin while busy
        send(MODE_WRITE, 7'h00, 8'hFF, 8'h00, 1'b1, 1'b0);
        send(MODE_NEXT, 7'h00, 8'h00, 8'hAA, 1'b1, 1'b0);   // byte already buffered
        // Let the next byte run late so SCL is held low
        while (bus_phase != BYTE_WAIT)
            send(MODE_TICK, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        repeat (3) send(MODE_TICK, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0);
        send(MODE_NEXT, 7'h00, 8'h00, 8'h00, 1'b1, 1'b0);
        send(MODE_NEXT, 7'h00, 8'h00, 8'h55, 1'b0, 1'b0);   // after the last byte
        run_to_idle(1'b0);
        // Read with every acknowledge missing and an all-ones byte
        send(MODE_READ, 7'h00, 8'hFF, 8'h00, 1'b0, 1'b1);
        send(MODE_NEXT, 7'h00, 8'h00, 8'h12, 1'b0, 1'b1);   // byte during a read
        run_to_idle(1'b1);
        // Read with clean acknowledges and an all-zero byte
        send(MODE_READ, 7'h7F, 8'h80, 8'h00, 1'b0, 1'b0);
        run_to_idle(1'b0);

        for (p = 0; p < N_PLANS; p++) begin
            set_timing(timing_plan[p][0], timing_plan[p][1], timing_plan[p][2]);
            no_gaps = (p == 1);
            repeat (timing_plan[p][3]) random_tick();
        end
        no_gaps = 1'b0;

        drain();
        repeat (10) @(posedge i_clk);
        $display("Ran %0d ticks over %0d timing settings", ticks_taken, N_PLANS + 1);
        $display("Finished %0d writes and %0d reads, %0d bytes read, %0d with a NACK",
                 n_writes, n_reads, n_rbytes, n_nacked);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
